FILE: src/rse_pkg.sv
`default_nettype none

package rse_pkg;

    // Sample and arithmetic widths
    localparam int SAMPLE_BITS = 16;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int SQR_BITS    = 2 * SAMPLE_BITS + 1;
    localparam int TERM_BITS   = SQR_BITS + 1;
    localparam int ACC_BITS    = 64;

    // Result format: unsigned Q32.16
    localparam int FRAC_BITS   = 16;
    localparam int INT_BITS    = 32;
    localparam int RATIO_BITS  = INT_BITS + FRAC_BITS;
    localparam int DVD_BITS    = ACC_BITS + FRAC_BITS;
    localparam int STEP_BITS   = $clog2(DVD_BITS);

    // Queue between front and back
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    // Final sums of one array
    typedef struct packed {
        logic [ACC_BITS-1:0] err;
        logic [ACC_BITS-1:0] eng;
    } sums_t;

    // Queue status seen by its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Divider sequencer
    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } bk_state_t;

endpackage

`default_nettype wire

FILE: src/rse_front.sv
`default_nettype none

module rse_front (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire logic signed [rse_pkg::SAMPLE_BITS-1:0] a_real,
    input  wire logic signed [rse_pkg::SAMPLE_BITS-1:0] a_imag,
    input  wire logic signed [rse_pkg::SAMPLE_BITS-1:0] b_real,
    input  wire logic signed [rse_pkg::SAMPLE_BITS-1:0] b_imag,
    input  wire                                   last,
    input  rse_pkg::q_status_t                    q_status,
    output logic                                  q_push,
    output rse_pkg::sums_t                        q_data
);

    // Stage 1: squared magnitudes
    logic                              s1_valid_reg, s1_valid_next;
    logic                              s1_last_reg;
    logic [rse_pkg::SQR_BITS-1:0]      sq_dr_reg, sq_di_reg, sq_ar_reg, sq_ai_reg;

    // Stage 2: per-item terms
    logic                              s2_valid_reg, s2_valid_next;
    logic                              s2_last_reg;
    logic [rse_pkg::TERM_BITS-1:0]     err_term_reg, eng_term_reg;

    // Accumulators
    logic [rse_pkg::ACC_BITS-1:0]      err_acc_reg, err_acc_next;
    logic [rse_pkg::ACC_BITS-1:0]      eng_acc_reg, eng_acc_next;

    logic                              advance;
    logic signed [rse_pkg::DIFF_BITS-1:0] ar_x, ai_x, dr, di;
    logic signed [rse_pkg::PROD_BITS-1:0] p_dr, p_di, p_ar, p_ai;
    logic [rse_pkg::ACC_BITS:0]        err_wide, eng_wide;
    logic [rse_pkg::ACC_BITS-1:0]      err_sum, eng_sum;

    // Whole pipeline holds only when a finished array cannot enter the queue
    assign advance  = !(s2_valid_reg && s2_last_reg && q_status.full);
    assign in_ready = advance;

    // Differences and squares of the incoming item
    always_comb
    begin
        ar_x = {a_real[rse_pkg::SAMPLE_BITS-1], a_real};
        ai_x = {a_imag[rse_pkg::SAMPLE_BITS-1], a_imag};
        dr   = ar_x - {b_real[rse_pkg::SAMPLE_BITS-1], b_real};
        di   = ai_x - {b_imag[rse_pkg::SAMPLE_BITS-1], b_imag};
        p_dr = dr * dr;
        p_di = di * di;
        p_ar = ar_x * ar_x;
        p_ai = ai_x * ai_x;
    end

    // Saturating accumulation
    always_comb
    begin
        err_wide = {1'b0, err_acc_reg} + (rse_pkg::ACC_BITS+1)'(err_term_reg);
        eng_wide = {1'b0, eng_acc_reg} + (rse_pkg::ACC_BITS+1)'(eng_term_reg);
        err_sum  = err_wide[rse_pkg::ACC_BITS] ? '1 : err_wide[rse_pkg::ACC_BITS-1:0];
        eng_sum  = eng_wide[rse_pkg::ACC_BITS] ? '1 : eng_wide[rse_pkg::ACC_BITS-1:0];
    end

    assign q_push     = advance && s2_valid_reg && s2_last_reg;
    assign q_data.err = err_sum;
    assign q_data.eng = eng_sum;

    // Next state of control and accumulators
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        err_acc_next  = err_acc_reg;
        eng_acc_next  = eng_acc_reg;
        if (advance)
        begin
            s1_valid_next = in_valid;
            s2_valid_next = s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    err_acc_next = '0;
                    eng_acc_next = '0;
                end
                else
                begin
                    err_acc_next = err_sum;
                    eng_acc_next = eng_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            err_acc_reg  <= '0;
            eng_acc_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            err_acc_reg  <= err_acc_next;
            eng_acc_reg  <= eng_acc_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg  <= last;
            sq_dr_reg    <= p_dr[rse_pkg::SQR_BITS-1:0];
            sq_di_reg    <= p_di[rse_pkg::SQR_BITS-1:0];
            sq_ar_reg    <= p_ar[rse_pkg::SQR_BITS-1:0];
            sq_ai_reg    <= p_ai[rse_pkg::SQR_BITS-1:0];
            s2_last_reg  <= s1_last_reg;
            err_term_reg <= {1'b0, sq_dr_reg} + {1'b0, sq_di_reg};
            eng_term_reg <= {1'b0, sq_ar_reg} + {1'b0, sq_ai_reg};
        end
    end

endmodule

`default_nettype wire

FILE: src/rse_queue.sv
`default_nettype none

module rse_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  rse_pkg::sums_t         push_data,
    input  wire                    pop,
    output rse_pkg::sums_t         pop_data,
    output rse_pkg::q_status_t     status
);

    rse_pkg::sums_t                  mem_reg [rse_pkg::Q_DEPTH];
    logic [rse_pkg::Q_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rse_pkg::Q_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rse_pkg::Q_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    assign status.full  = (cnt_reg == rse_pkg::Q_CNT_BITS'(rse_pkg::Q_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rse_pkg::Q_PTR_BITS'(rse_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rse_pkg::Q_PTR_BITS'(rse_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/rse_back.sv
`default_nettype none

module rse_back (
    input  wire                              clk,
    input  wire                              rst_n,
    input  rse_pkg::q_status_t               q_status,
    input  rse_pkg::sums_t                   q_data,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [rse_pkg::RATIO_BITS-1:0]   ratio,
    output logic                             floored
);

    rse_pkg::bk_state_t                 state_reg, state_next;
    logic [rse_pkg::STEP_BITS-1:0]      step_reg, step_next;
    logic [rse_pkg::ACC_BITS-1:0]       rem_reg, rem_next;
    logic [rse_pkg::DVD_BITS-1:0]       dvd_reg, dvd_next;
    logic [rse_pkg::ACC_BITS-1:0]       den_reg, den_next;
    logic [rse_pkg::RATIO_BITS-1:0]     quo_reg, quo_next;
    logic                               sat_reg, sat_next;
    logic                               fl_reg, fl_next;
    logic                               out_valid_reg, out_valid_next;
    logic [rse_pkg::RATIO_BITS-1:0]     ratio_reg;
    logic                               floored_reg;

    logic [rse_pkg::ACC_BITS:0]         rem_shift, rem_diff;
    logic                               ge;
    logic                               zero_eng;
    logic                               load_out;

    assign out_valid = out_valid_reg;
    assign ratio     = ratio_reg;
    assign floored   = floored_reg;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[rse_pkg::DVD_BITS-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        ge        = (rem_shift >= {1'b0, den_reg});
    end

    assign zero_eng = (q_data.eng == '0);
    assign q_pop    = (state_reg == rse_pkg::BK_IDLE) && !q_status.empty;
    assign load_out = (state_reg == rse_pkg::BK_DONE) && (!out_valid_reg || out_ready);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        sat_next       = sat_reg;
        fl_next        = fl_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            rse_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    dvd_next   = {q_data.err, {rse_pkg::FRAC_BITS{1'b0}}};
                    den_next   = zero_eng ? rse_pkg::ACC_BITS'(1) : q_data.eng;
                    fl_next    = zero_eng;
                    quo_next   = '0;
                    sat_next   = 1'b0;
                    state_next = rse_pkg::BK_DIV;
                end
            end
            rse_pkg::BK_DIV:
            begin
                rem_next  = ge ? rem_diff[rse_pkg::ACC_BITS-1:0]
                               : rem_shift[rse_pkg::ACC_BITS-1:0];
                dvd_next  = {dvd_reg[rse_pkg::DVD_BITS-2:0], 1'b0};
                quo_next  = {quo_reg[rse_pkg::RATIO_BITS-2:0], ge};
                // a one pushed past the top means the integer part hit 2^32
                sat_next  = sat_reg | quo_reg[rse_pkg::RATIO_BITS-1];
                step_next = step_reg + 1'b1;
                if (step_reg == rse_pkg::STEP_BITS'(rse_pkg::DVD_BITS - 1))
                begin
                    state_next = rse_pkg::BK_DONE;
                end
            end
            rse_pkg::BK_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = rse_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rse_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rse_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Divider datapath and result register
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
        fl_reg   <= fl_next;
        if (load_out)
        begin
            ratio_reg   <= sat_reg ? '1 : quo_reg;
            floored_reg <= fl_reg;
        end
    end

endmodule

`default_nettype wire

FILE: src/relative_squared_error_top.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     a_real, a_imag, b_real, b_imag (s16), last
// output    out_valid / out_ready   ratio (u48, Q32.16), floored
//
// The front takes one item per cycle while in_ready is high; two pipeline
// stages square and accumulate. The back runs each array end through the
// bit-serial restoring divider (80 quotient bits, one per cycle), then load
// and hand-off. A two-entry queue holds finished sums; in_ready drops only
// when an array end meets a full queue. Reset clears accumulators and control.
`default_nettype none

module relative_squared_error_top (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire logic signed [rse_pkg::SAMPLE_BITS-1:0] a_real,
    input  wire logic signed [rse_pkg::SAMPLE_BITS-1:0] a_imag,
    input  wire logic signed [rse_pkg::SAMPLE_BITS-1:0] b_real,
    input  wire logic signed [rse_pkg::SAMPLE_BITS-1:0] b_imag,
    input  wire                                   last,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [rse_pkg::RATIO_BITS-1:0]        ratio,
    output logic                                  floored
);

    rse_pkg::q_status_t q_status;
    rse_pkg::sums_t     push_data;
    rse_pkg::sums_t     pop_data;
    logic               q_push;
    logic               q_pop;

    // Accumulating front
    rse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .last     (last),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    // Sums waiting for the divider
    rse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Dividing back
    rse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ratio     (ratio),
        .floored   (floored)
    );

endmodule

`default_nettype wire
